/* hw/rtl/cfd_pkg.sv */
// Shared types, constants and helpers for the camera frame deframer.
// No dependencies; used by cfd_core and camera_frame_deframer.
`default_nettype none

package cfd_pkg;

    localparam int MAX_DIM   = 1024;
    localparam int DIM_W     = 11;
    localparam int POS_W     = 10;
    localparam int BYTE_W    = 8;
    localparam int PIX_W     = 16;
    localparam int SYNC_LEN  = 5;
    localparam int MATCH_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 40;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd160;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd120;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } pixel_t;

    typedef struct packed {
        logic loading;
        logic second_due;
    } core_status_t;

    // Sync word "START", one character per match position.
    function automatic logic [BYTE_W-1:0] sync_char(input logic [MATCH_W-1:0] pos);
        logic [BYTE_W-1:0] c;
        begin
            case (pos)
                3'd0:    c = 8'h53;
                3'd1:    c = 8'h54;
                3'd2:    c = 8'h41;
                3'd3:    c = 8'h52;
                3'd4:    c = 8'h54;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // Zero acts as one, anything above the maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        begin
            if (v == '0)
                d = DIM_W'(1);
            else if (v > DIM_W'(MAX_DIM))
                d = DIM_W'(MAX_DIM);
            else
                d = v;
            return d;
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cfd_core.sv */
// Sync hunt and pixel assembly state for the camera frame deframer.
// Depends on cfd_pkg for types, the sync word and dimension clamping.
`default_nettype none

module cfd_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [cfd_pkg::BYTE_W-1:0] rx_byte,
    input  wire logic [cfd_pkg::DIM_W-1:0]  frame_width,
    input  wire logic [cfd_pkg::DIM_W-1:0]  frame_height,
    output logic                            pix_valid,
    output cfd_pkg::pixel_t                 pixel,
    output cfd_pkg::core_status_t           status
);

    logic                         loading_reg, loading_next;
    logic [cfd_pkg::MATCH_W-1:0]  match_reg, match_next;
    logic [cfd_pkg::BYTE_W-1:0]   high_reg, high_next;
    logic                         second_reg, second_next;
    logic [cfd_pkg::POS_W-1:0]    col_reg, col_next;
    logic [cfd_pkg::POS_W-1:0]    row_reg, row_next;

    logic [cfd_pkg::DIM_W-1:0]    w_eff, h_eff;
    logic [cfd_pkg::DIM_W-1:0]    col_inc, row_inc;
    logic [cfd_pkg::MATCH_W-1:0]  match_inc;
    logic                         row_end, last;

    assign w_eff     = cfd_pkg::eff_dim(frame_width);
    assign h_eff     = cfd_pkg::eff_dim(frame_height);
    assign col_inc   = {1'b0, col_reg} + cfd_pkg::DIM_W'(1);
    assign row_inc   = {1'b0, row_reg} + cfd_pkg::DIM_W'(1);
    assign row_end   = col_inc >= w_eff;
    assign last      = row_end && (row_inc >= h_eff);
    assign match_inc = match_reg + cfd_pkg::MATCH_W'(1);

    assign pix_valid   = loading_reg && second_reg;
    assign pixel.value = {high_reg, rx_byte};
    assign pixel.col   = col_reg;
    assign pixel.row   = row_reg;
    assign pixel.last  = last;

    assign status.loading    = loading_reg;
    assign status.second_due = second_reg;

    always_comb
    begin
        loading_next = loading_reg;
        match_next   = match_reg;
        high_next    = high_reg;
        second_next  = second_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        if (accept)
        begin
            if (!loading_reg)
            begin
                if (rx_byte == cfd_pkg::sync_char(match_reg))
                    match_next = match_inc;
                else if (rx_byte == cfd_pkg::sync_char('0))
                    match_next = cfd_pkg::MATCH_W'(1);
                else
                    match_next = '0;
                // full sync word seen: start a fresh frame
                if (match_next == cfd_pkg::MATCH_W'(cfd_pkg::SYNC_LEN))
                begin
                    match_next   = '0;
                    loading_next = 1'b1;
                    second_next  = 1'b0;
                    col_next     = '0;
                    row_next     = '0;
                end
            end
            else if (!second_reg)
            begin
                high_next   = rx_byte;
                second_next = 1'b1;
            end
            else
            begin
                second_next = 1'b0;
                if (last)
                begin
                    loading_next = 1'b0;
                    col_next     = '0;
                    row_next     = '0;
                end
                else if (row_end)
                begin
                    col_next = '0;
                    row_next = row_inc[cfd_pkg::POS_W-1:0];
                end
                else
                begin
                    col_next = col_inc[cfd_pkg::POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loading_reg <= 1'b0;
            match_reg   <= '0;
            high_reg    <= '0;
            second_reg  <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else
        begin
            loading_reg <= loading_next;
            match_reg   <= match_next;
            high_reg    <= high_next;
            second_reg  <= second_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/camera_frame_deframer.sv */
// Top level of the camera frame deframer: config registers, stream ports, result register.
// Depends on cfd_pkg and cfd_core.
`default_nettype none

// Takes one byte per request from a serial camera link, hunts for the sync
// word "START", then assembles frame_width x frame_height RGB565 pixels (high
// byte first, row order) and emits one result per pixel with its column and
// row; tlast marks the frame's last pixel, after which hunting resumes. One
// byte is taken every cycle: the core state updates in the cycle a byte is
// accepted, and the single result register accepts a new pixel in the same
// cycle the previous one is taken, so a byte is stalled only while an
// unclaimed result is held. Dimension registers of 0 act as 1, above 1024 as
// 1024; write them only while the block is idle.

module camera_frame_deframer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [cfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cfd_pkg::DIM_W-1:0]     cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,  // [7:0] rx_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [15:0] pixel_value, [25:16] pixel_col, [35:26] pixel_row, [39:36] zero
    output logic [cfd_pkg::OUT_W-1:0]          m_tdata,
    output logic                               m_tlast   // frame_last
);

    logic [cfd_pkg::DIM_W-1:0] width_reg, height_reg;
    logic                      out_valid_reg;
    cfd_pkg::pixel_t           out_reg;

    logic                      in_acc;
    logic                      pix_valid;
    cfd_pkg::pixel_t           pixel;
    cfd_pkg::core_status_t     status;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cfd_pkg::WIDTH_RESET;
            height_reg <= cfd_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cfd_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                cfd_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cfd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_acc),
        .rx_byte      (s_tdata),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .pix_valid    (pix_valid),
        .pixel        (pixel),
        .status       (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_acc && pix_valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // hold the result until taken; load a new one when a pixel completes
    always_ff @(posedge clk)
    begin
        if (in_acc && pix_valid)
            out_reg <= pixel;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.row, out_reg.col, out_reg.value};
    assign m_tlast  = out_reg.last;

    // a completed pixel always lands in the result register
    a_pixel_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && pix_valid |=> m_tvalid && (m_tlast == $past(pixel.last)))
        else $error("completed pixel not presented");

    // the final pixel of a frame drops back to hunting
    a_last_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && pix_valid && pixel.last |=> !status.loading)
        else $error("no return to hunting after last pixel");

    // a new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
